FILE: rtl/apsc_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive PI speed controller package
// Shared widths, reset values, register indexes and interface types.
// ----------------------------------------------------------------------------
package apsc_pkg;

  localparam int unsigned GainW    = 16;
  localparam int unsigned LimitW   = 15;
  localparam int unsigned IntegW   = 16;
  localparam int unsigned PulseW   = 11;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam logic [15:0]       RefSpeedRst      = 16'd15;
  localparam logic [GainW-1:0]  PropGainBaseRst  = 16'd7680;
  localparam logic [GainW-1:0]  IntegGainBaseRst = 16'd1280;
  localparam logic [GainW-1:0]  PropGainSatRst   = 16'd2560;
  localparam logic [GainW-1:0]  IntegGainSatRst  = 16'd256;
  localparam logic [LimitW-1:0] IntegLimitRst    = 15'd12800;
  localparam logic [GainW-1:0]  BlendFactorRst   = 16'd19661;
  localparam logic [GainW-1:0]  DecayFactorRst   = 16'd62259;

  localparam logic [PulseW-1:0] PulseMin     = 11'd1000;
  localparam logic [PulseW-1:0] PulseMax     = 11'd2000;
  localparam logic [PulseW-1:0] PulseNeutral = 11'd1500;
  localparam logic [PulseW-1:0] SatLow       = 11'd1050;
  localparam logic [PulseW-1:0] SatHigh      = 11'd1950;

  typedef enum logic [2:0] {
    REG_REF_SPEED       = 3'd0,
    REG_PROP_GAIN_BASE  = 3'd1,
    REG_INTEG_GAIN_BASE = 3'd2,
    REG_PROP_GAIN_SAT   = 3'd3,
    REG_INTEG_GAIN_SAT  = 3'd4,
    REG_INTEG_LIMIT     = 3'd5,
    REG_BLEND_FACTOR    = 3'd6,
    REG_DECAY_FACTOR    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  prop_gain_base;
    logic [GainW-1:0]  integ_gain_base;
    logic [GainW-1:0]  prop_gain_sat;
    logic [GainW-1:0]  integ_gain_sat;
    logic [LimitW-1:0] integral_limit;
    logic [GainW-1:0]  blend_factor;
    logic [GainW-1:0]  decay_factor;
  } cfg_t;

  typedef struct packed {
    logic signed [IntegW-1:0] integral;
    logic [GainW-1:0]         prop_gain;
    logic [GainW-1:0]         integ_gain;
  } loop_state_t;

  typedef struct packed {
    logic [PulseW-1:0]        pulse_width;
    logic                     saturated;
    logic signed [IntegW-1:0] integral;
    logic [GainW-1:0]         prop_gain;
    logic [GainW-1:0]         integ_gain;
  } result_t;

endpackage

FILE: rtl/adaptive_pi_speed_controller.sv
// ----------------------------------------------------------------------------
// Adaptive PI speed controller
// Measured words wait in the input register, results in the result register.
// Throughput: one word per cycle unless the output stalls; integral and gain
// feedback closes through the single step datapath between these registers.
// Reset: asynchronous, active low; clears both valid flags, restores the loop
// state (integral 0, gains 7680 and 1280) and the configuration defaults.
// ----------------------------------------------------------------------------
module adaptive_pi_speed_controller #(
  parameter int unsigned SPEED_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apsc_pkg::ApbAddrW-1:0] paddr,
  input  logic [apsc_pkg::ApbDataW-1:0] pwdata,
  output logic [apsc_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SPEED_BITS-1:0]         measured_speed_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [apsc_pkg::PulseW-1:0]   pulse_width_o,
  output logic                          saturated_o,
  output logic signed [apsc_pkg::IntegW-1:0] integral_now_o,
  output logic [apsc_pkg::GainW-1:0]    prop_gain_now_o,
  output logic [apsc_pkg::GainW-1:0]    integ_gain_now_o
);
  import apsc_pkg::*;

  logic [SPEED_BITS-1:0] reference_speed;
  cfg_t                  cfg;

  logic                  in_valid_q, in_valid_d;
  logic [SPEED_BITS-1:0] meas_q, meas_d;
  logic                  out_valid_q, out_valid_d;
  result_t               result_q, result_d;
  loop_state_t           state_q, state_d;
  result_t               step_res;
  logic                  advance;
  logic                  accept;

  apsc_regs #(
    .SPEED_BITS (SPEED_BITS)
  ) u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .reference_speed_o (reference_speed),
    .cfg_o             (cfg)
  );

  apsc_step #(
    .SPEED_BITS (SPEED_BITS)
  ) u_step (
    .reference_speed_i (reference_speed),
    .measured_speed_i  (meas_q),
    .cfg_i             (cfg),
    .state_i           (state_q),
    .result_o          (step_res)
  );

  // A held word moves on whenever the result register is free or being emptied.
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    meas_d      = accept ? measured_speed_i : meas_q;
    out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    result_d    = advance ? step_res : result_q;
    state_d     = state_q;
    if (advance) begin
      state_d.integral   = step_res.integral;
      state_d.prop_gain  = step_res.prop_gain;
      state_d.integ_gain = step_res.integ_gain;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      state_q.integral   <= '0;
      state_q.prop_gain  <= PropGainBaseRst;
      state_q.integ_gain <= IntegGainBaseRst;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q   <= meas_d;
    result_q <= result_d;
  end

  assign out_valid_o      = out_valid_q;
  assign pulse_width_o    = result_q.pulse_width;
  assign saturated_o      = result_q.saturated;
  assign integral_now_o   = result_q.integral;
  assign prop_gain_now_o  = result_q.prop_gain;
  assign integ_gain_now_o = result_q.integ_gain;

endmodule

FILE: rtl/apsc_regs.sv
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style slave holding the reference and the controller tuning values.
// ----------------------------------------------------------------------------
module apsc_regs #(
  parameter int unsigned SPEED_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [apsc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [apsc_pkg::ApbDataW-1:0]  pwdata,
  output logic [apsc_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output logic [SPEED_BITS-1:0]          reference_speed_o,
  output apsc_pkg::cfg_t                 cfg_o
);
  import apsc_pkg::*;

  logic [SPEED_BITS-1:0] ref_speed_q, ref_speed_d;
  cfg_t                  cfg_q, cfg_d;
  reg_idx_e              idx;
  logic                  wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    ref_speed_d = ref_speed_q;
    cfg_d       = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_REF_SPEED:       ref_speed_d = pwdata[SPEED_BITS-1:0];
        REG_PROP_GAIN_BASE:  cfg_d.prop_gain_base = pwdata[GainW-1:0];
        REG_INTEG_GAIN_BASE: cfg_d.integ_gain_base = pwdata[GainW-1:0];
        REG_PROP_GAIN_SAT:   cfg_d.prop_gain_sat = pwdata[GainW-1:0];
        REG_INTEG_GAIN_SAT:  cfg_d.integ_gain_sat = pwdata[GainW-1:0];
        REG_INTEG_LIMIT:     cfg_d.integral_limit = pwdata[LimitW-1:0];
        REG_BLEND_FACTOR:    cfg_d.blend_factor = pwdata[GainW-1:0];
        REG_DECAY_FACTOR:    cfg_d.decay_factor = pwdata[GainW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_speed_q           <= RefSpeedRst[SPEED_BITS-1:0];
      cfg_q.prop_gain_base  <= PropGainBaseRst;
      cfg_q.integ_gain_base <= IntegGainBaseRst;
      cfg_q.prop_gain_sat   <= PropGainSatRst;
      cfg_q.integ_gain_sat  <= IntegGainSatRst;
      cfg_q.integral_limit  <= IntegLimitRst;
      cfg_q.blend_factor    <= BlendFactorRst;
      cfg_q.decay_factor    <= DecayFactorRst;
    end else begin
      ref_speed_q <= ref_speed_d;
      cfg_q       <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_REF_SPEED:       prdata = ApbDataW'(ref_speed_q);
      REG_PROP_GAIN_BASE:  prdata = ApbDataW'(cfg_q.prop_gain_base);
      REG_INTEG_GAIN_BASE: prdata = ApbDataW'(cfg_q.integ_gain_base);
      REG_PROP_GAIN_SAT:   prdata = ApbDataW'(cfg_q.prop_gain_sat);
      REG_INTEG_GAIN_SAT:  prdata = ApbDataW'(cfg_q.integ_gain_sat);
      REG_INTEG_LIMIT:     prdata = ApbDataW'(cfg_q.integral_limit);
      REG_BLEND_FACTOR:    prdata = ApbDataW'(cfg_q.blend_factor);
      REG_DECAY_FACTOR:    prdata = ApbDataW'(cfg_q.decay_factor);
      default:             prdata = '0;
    endcase
  end

  assign reference_speed_o = ref_speed_q;
  assign cfg_o             = cfg_q;

endmodule

FILE: rtl/apsc_blend.sv
// ----------------------------------------------------------------------------
// Gain blend
// Moves a Q8.8 gain toward a target by an unsigned Q0.16 weight.
// ----------------------------------------------------------------------------
module apsc_blend (
  input  logic [apsc_pkg::GainW-1:0] gain_i,
  input  logic [apsc_pkg::GainW-1:0] target_i,
  input  logic [apsc_pkg::GainW-1:0] weight_i,
  output logic [apsc_pkg::GainW-1:0] gain_o
);
  import apsc_pkg::*;

  logic signed [GainW:0]     diff;
  logic signed [2*GainW+1:0] prod;
  logic signed [GainW+2:0]   sum;

  // g*(1-b) + t*b equals g + (t-g)*b, and the floor shift carries over exactly.
  assign diff = $signed({1'b0, target_i}) - $signed({1'b0, gain_i});
  assign prod = diff * $signed({1'b0, weight_i});
  assign sum  = (GainW+3)'($signed({1'b0, gain_i})) +
                (GainW+3)'($signed(prod[2*GainW+1:GainW]));
  assign gain_o = sum[GainW-1:0];

endmodule

FILE: rtl/apsc_step.sv
// ----------------------------------------------------------------------------
// Controller step datapath
// Error, clamped integral, PI output with saturation check, integral decay
// and gain scheduling for one measured word.
// ----------------------------------------------------------------------------
module apsc_step #(
  parameter int unsigned SPEED_BITS = 10
) (
  input  logic [SPEED_BITS-1:0] reference_speed_i,
  input  logic [SPEED_BITS-1:0] measured_speed_i,
  input  apsc_pkg::cfg_t        cfg_i,
  input  apsc_pkg::loop_state_t state_i,
  output apsc_pkg::result_t     result_o
);
  import apsc_pkg::*;

  localparam int unsigned ErrW    = SPEED_BITS + 1;
  localparam int unsigned SumW    = ((ErrW + 8 > IntegW) ? ErrW + 8 : IntegW) + 1;
  localparam int unsigned PropW   = GainW + 1 + ErrW;
  localparam int unsigned IntW    = GainW + 1 + IntegW;
  localparam int unsigned CtlW    = ((PropW + 8 > IntW) ? PropW + 8 : IntW) + 1;
  localparam int unsigned PulseSW = CtlW - 14;

  logic signed [ErrW-1:0]     err;
  logic signed [SumW-1:0]     integ_sum;
  logic signed [SumW-1:0]     lim;
  logic signed [IntegW-1:0]   integ_clamp;
  logic signed [PropW-1:0]    prop_prod;
  logic signed [IntW-1:0]     integ_prod;
  logic signed [CtlW-1:0]     ctl;
  logic signed [CtlW-1:0]     ctl_adj;
  logic signed [PulseSW-1:0]  pulse_raw;
  logic                       sat;
  logic [PulseW-1:0]          pulse;
  logic signed [IntegW*2:0]   decay_prod;
  logic [GainW-1:0]           prop_to_base, prop_to_sat;
  logic [GainW-1:0]           integ_to_base, integ_to_sat;

  assign err = $signed({1'b0, reference_speed_i}) - $signed({1'b0, measured_speed_i});

  assign integ_sum = (SumW'(err) <<< 8) + SumW'(state_i.integral);
  assign lim       = SumW'($signed({1'b0, cfg_i.integral_limit}));

  always_comb begin
    if (integ_sum > lim) begin
      integ_clamp = lim[IntegW-1:0];
    end else if (integ_sum < -lim) begin
      integ_clamp = IntegW'(-lim);
    end else begin
      integ_clamp = integ_sum[IntegW-1:0];
    end
  end

  assign prop_prod  = $signed({1'b0, state_i.prop_gain}) * err;
  assign integ_prod = $signed({1'b0, state_i.integ_gain}) * integ_clamp;
  assign ctl        = (CtlW'(prop_prod) <<< 8) + CtlW'(integ_prod);

  // Bias negative values so the shift truncates toward zero.
  assign ctl_adj   = ctl[CtlW-1] ? (ctl + CtlW'(65535)) : ctl;
  assign pulse_raw = PulseSW'($signed(ctl_adj[CtlW-1:16])) +
                     PulseSW'($signed({1'b0, PulseNeutral}));

  assign sat = (pulse_raw < PulseSW'($signed({1'b0, SatLow}))) ||
               (pulse_raw > PulseSW'($signed({1'b0, SatHigh})));

  always_comb begin
    if (pulse_raw < PulseSW'($signed({1'b0, PulseMin}))) begin
      pulse = PulseMin;
    end else if (pulse_raw > PulseSW'($signed({1'b0, PulseMax}))) begin
      pulse = PulseMax;
    end else begin
      pulse = pulse_raw[PulseW-1:0];
    end
  end

  // The floor shift never grows the magnitude, so the upper word is the result.
  assign decay_prod = integ_clamp * $signed({1'b0, cfg_i.decay_factor});

  apsc_blend u_prop_base (
    .gain_i   (state_i.prop_gain),
    .target_i (cfg_i.prop_gain_base),
    .weight_i (cfg_i.blend_factor),
    .gain_o   (prop_to_base)
  );

  apsc_blend u_prop_sat (
    .gain_i   (state_i.prop_gain),
    .target_i (cfg_i.prop_gain_sat),
    .weight_i (cfg_i.blend_factor),
    .gain_o   (prop_to_sat)
  );

  apsc_blend u_integ_base (
    .gain_i   (state_i.integ_gain),
    .target_i (cfg_i.integ_gain_base),
    .weight_i (cfg_i.blend_factor),
    .gain_o   (integ_to_base)
  );

  apsc_blend u_integ_sat (
    .gain_i   (state_i.integ_gain),
    .target_i (cfg_i.integ_gain_sat),
    .weight_i (cfg_i.blend_factor),
    .gain_o   (integ_to_sat)
  );

  always_comb begin
    result_o.pulse_width = pulse;
    result_o.saturated   = sat;
    result_o.integral    = sat ? decay_prod[2*IntegW-1:IntegW] : integ_clamp;
    result_o.prop_gain   = sat ? prop_to_sat : prop_to_base;
    result_o.integ_gain  = sat ? integ_to_sat : integ_to_base;
  end

endmodule
